// ----- rtl/core/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
package skt_pkg;

	localparam int unsigned DEPTH_DEF    = 256;
	localparam int unsigned KEY_BITS_DEF = 32;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned ACT_W        = 3;
	localparam int unsigned CAP_W        = 9;
	localparam int unsigned IDX_W        = 8;
	localparam int unsigned CNT_W        = 9;

	localparam logic [0:0] REG_CAPACITY = 1'd0;
	localparam logic [0:0] REG_SIGNED   = 1'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_LOOKUP = 3'd3,
		ACT_SORT   = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_LK_RD,
		ST_LK_CMP,
		ST_SORT_GAP,
		ST_SORT_I,
		ST_SORT_V,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_DONE
	} state_t;

	// Result of one action, held until taken downstream.
	typedef struct packed {
		logic             status;
		logic             found;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

// ----- rtl/core/sorted_key_table.sv -----
// Sorted key table: append, sorted insert, binary lookup, Shell sort on one key RAM.
// Clear, append, dropped and unknown actions go straight to the result; insert reads
// and shifts up each larger key until the key's slot is found; lookup reads and compares
// one binary-search probe at a time; sort grows the gap, then moves elements per pass.
// One item at a time; next beat taken the cycle after the result moves to the output register.
// Reset clears the count, capacity to 256 and unsigned order; key RAM is not cleared.
module sorted_key_table #(
	parameter int unsigned DEPTH    = skt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action[2:0], key[34:3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status, found, index[9:2], count[18:10], zero pad
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [skt_pkg::CAP_W-1:0] cap_q;
	logic                      sgn_q;
	logic                      out_v_q;
	skt_pkg::result_t          out_q, res;
	logic                      busy, done, start, we, res_ready;
	logic [AW-1:0]             waddr, raddr;
	logic [KEY_BITS-1:0]       wdata, rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= skt_pkg::CAP_W'(256);
			sgn_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				skt_pkg::REG_CAPACITY: cap_q <= cfg_data;
				skt_pkg::REG_SIGNED:   sgn_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready  = !busy;
	assign start     = s_tvalid && s_tready;
	assign res_ready = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done && res_ready) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_ready) out_q <= res;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q.count, out_q.index, out_q.found, out_q.status};

	skt_ctrl #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_ctrl (
		.clk, .arst_n, .start,
		.act(skt_pkg::action_t'(s_tdata[2:0])),
		.key_in(s_tdata[3 +: KEY_BITS]),
		.capacity(cap_q), .signed_order(sgn_q), .res_ready,
		.busy, .done, .res, .we, .waddr, .wdata, .raddr, .rdata
	);

	skt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("item taken while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.count <= skt_pkg::CNT_W'(DEPTH))) else $error("count overflow");
	a_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !out_q.found) |-> (out_q.index == '0)) else $error("index without match");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed while stalled");

endmodule

// ----- rtl/core/skt_ram.sv -----
// Generic RAM, one write port and one read port, with registered read.
module skt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/skt_ctrl.sv -----
// Sequencer: runs each action as reads, compares and write-backs on the key RAM.
module skt_ctrl #(
	parameter int unsigned DEPTH    = skt_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  skt_pkg::action_t               act,
	input  logic [KEY_BITS-1:0]            key_in,
	input  logic [skt_pkg::CAP_W-1:0]      capacity,
	input  logic                           signed_order,
	input  logic                           res_ready,
	output logic                           busy,
	output logic                           done,
	output skt_pkg::result_t               res,
	output logic                           we,
	output logic [$clog2(DEPTH)-1:0]       waddr,
	output logic [KEY_BITS-1:0]            wdata,
	output logic [$clog2(DEPTH)-1:0]       raddr,
	input  logic [KEY_BITS-1:0]            rdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned NW = $clog2(DEPTH + 1) + 2;
	// inverse of 3 modulo 2^NW; a Knuth gap minus one is an exact multiple of 3
	localparam logic [NW-1:0] INV3 = NW'({NW{2'b10}}) + NW'(1);

	skt_pkg::state_t state_q, state_d;
	logic [NW-1:0]       fill_q, fill_d;
	logic [KEY_BITS-1:0] key_q, key_d, v_q, v_d;
	logic [NW-1:0]       i_q, i_d, j_q, j_d, h_q, h_d, lo_q, lo_d, hi_q, hi_d;
	logic                status_q, status_d, found_q, found_d;
	logic [NW-1:0]       idx_q, idx_d;
	logic [NW-1:0]       lim, mid;
	logic [NW-1:0]       h3, h_dn;
	logic [KEY_BITS-1:0] ka, kb;
	logic                lt, gt;
	logic [KEY_BITS-1:0] sgn;
	logic [NW-1:0]       raddr_w, waddr_w;

	assign sgn = {signed_order, {(KEY_BITS-1){1'b0}}};
	// compare key_q/v_q (a) against RAM word (b)
	always_comb begin
		ka = ((state_q == skt_pkg::ST_SORT_CMP) ? v_q : key_q) ^ sgn;
		kb = rdata ^ sgn;
		lt = ka < kb;
		gt = ka > kb;
	end

	always_comb begin
		if (capacity == '0) begin
			lim = NW'(1);
		end else if (32'(capacity) > DEPTH) begin
			lim = NW'(DEPTH);
		end else begin
			lim = NW'(capacity);
		end
		mid  = (lo_q + hi_q) >> 1;
		h3   = (h_q << 1) + h_q + NW'(1);
		// next smaller gap: (h - 1) / 3, exact
		h_dn = (h_q - NW'(1)) * INV3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d; v_q <= v_d; i_q <= i_d; j_q <= j_d; h_q <= h_d;
		lo_q <= lo_d; hi_q <= hi_d; status_q <= status_d; found_q <= found_d;
		idx_q <= idx_d;
	end

	always_comb begin
		state_d = state_q; fill_d = fill_q; key_d = key_q; v_d = v_q;
		i_d = i_q; j_d = j_q; h_d = h_q; lo_d = lo_q; hi_d = hi_q;
		status_d = status_q; found_d = found_q; idx_d = idx_q;
		we = 1'b0; waddr_w = '0; wdata = key_q; raddr_w = '0;
		unique case (state_q)
			skt_pkg::ST_IDLE: begin
				if (start) begin
					key_d = key_in; status_d = 1'b0; found_d = 1'b0; idx_d = '0;
					state_d = skt_pkg::ST_DONE;
					unique case (act)
						skt_pkg::ACT_CLEAR: fill_d = '0;
						skt_pkg::ACT_APPEND: begin
							if (fill_q < lim) begin
								we = 1'b1; waddr_w = fill_q; wdata = key_in;
								fill_d = fill_q + NW'(1);
							end else begin
								status_d = 1'b1;
							end
						end
						skt_pkg::ACT_INSERT: begin
							if (fill_q < lim) begin
								i_d = fill_q;
								fill_d = fill_q + NW'(1);
								state_d = skt_pkg::ST_INS_RD;
							end else begin
								status_d = 1'b1;
							end
						end
						skt_pkg::ACT_LOOKUP: begin
							lo_d = '0; hi_d = fill_q;
							state_d = skt_pkg::ST_LK_RD;
						end
						skt_pkg::ACT_SORT: begin
							h_d = NW'(1);
							state_d = skt_pkg::ST_SORT_GAP;
						end
						default: ;
					endcase
				end
			end
			// insert: read entries[i-1], shift up while larger, place key in the freed slot
			skt_pkg::ST_INS_RD: begin
				if (i_q == '0) begin
					we = 1'b1; waddr_w = '0; wdata = key_q;
					state_d = skt_pkg::ST_DONE;
				end else begin
					raddr_w = i_q - NW'(1);
					state_d = skt_pkg::ST_INS_CMP;
				end
			end
			skt_pkg::ST_INS_CMP: begin
				we = 1'b1; waddr_w = i_q;
				if (lt) begin
					wdata = rdata;
					i_d = i_q - NW'(1);
					state_d = skt_pkg::ST_INS_RD;
				end else begin
					wdata = key_q;
					state_d = skt_pkg::ST_DONE;
				end
			end
			skt_pkg::ST_LK_RD: begin
				if (hi_q > lo_q) begin
					raddr_w = mid;
					state_d = skt_pkg::ST_LK_CMP;
				end else begin
					state_d = skt_pkg::ST_DONE;
				end
			end
			skt_pkg::ST_LK_CMP: begin
				state_d = skt_pkg::ST_LK_RD;
				if (!lt && !gt) begin
					found_d = 1'b1; idx_d = mid; state_d = skt_pkg::ST_DONE;
				end else if (gt) begin
					lo_d = mid + NW'(1);
				end else begin
					hi_d = mid;
				end
			end
			// grow h past n, then step down h/3
			skt_pkg::ST_SORT_GAP: begin
				if (h_q <= fill_q) begin
					h_d = h3;
				end else if (h_q == NW'(1)) begin
					state_d = skt_pkg::ST_DONE;
				end else begin
					h_d = h_dn;
					i_d = h_dn;
					state_d = skt_pkg::ST_SORT_I;
				end
			end
			skt_pkg::ST_SORT_I: begin
				if (i_q < fill_q) begin
					raddr_w = i_q;
					j_d = i_q;
					state_d = skt_pkg::ST_SORT_V;
				end else if (h_q == NW'(1)) begin
					state_d = skt_pkg::ST_DONE;
				end else begin
					h_d = h_dn; i_d = h_dn;
				end
			end
			skt_pkg::ST_SORT_V: begin
				v_d = rdata;
				if (j_q >= h_q) begin
					raddr_w = j_q - h_q;
					state_d = skt_pkg::ST_SORT_CMP;
				end else begin
					state_d = skt_pkg::ST_SORT_PUT;
				end
			end
			skt_pkg::ST_SORT_CMP: begin
				if (lt) begin
					we = 1'b1; waddr_w = j_q; wdata = rdata;
					j_d = j_q - h_q;
					if (j_q - h_q >= h_q) begin
						raddr_w = j_q - h_q - h_q;
					end else begin
						state_d = skt_pkg::ST_SORT_PUT;
					end
				end else begin
					state_d = skt_pkg::ST_SORT_PUT;
				end
			end
			skt_pkg::ST_SORT_PUT: begin
				we = 1'b1; waddr_w = j_q; wdata = v_q;
				i_d = i_q + NW'(1);
				state_d = skt_pkg::ST_SORT_I;
			end
			// hold the result until the output register can take it
			skt_pkg::ST_DONE: begin
				if (res_ready) state_d = skt_pkg::ST_IDLE;
			end
			default: state_d = skt_pkg::ST_IDLE;
		endcase
	end

	assign raddr = raddr_w[AW-1:0];
	assign waddr = waddr_w[AW-1:0];
	assign busy  = state_q != skt_pkg::ST_IDLE;
	assign done  = state_q == skt_pkg::ST_DONE;
	assign res.status = status_q;
	assign res.found  = found_q;
	assign res.index  = idx_q[skt_pkg::IDX_W-1:0];
	assign res.count  = fill_q[skt_pkg::CNT_W-1:0];

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking sorted key table testbench: directed rows, random actions, full depth.
module testbench;
	import skt_pkg::*;

	localparam int NDEPTH = 256;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] key;
		logic        chk;   // typed-in expectation present
		logic        e_status;
		logic        e_found;
		logic [7:0]  e_index;
		logic [8:0]  e_count;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	logic [31:0] keys[NDEPTH];
	int unsigned fill_cnt;
	logic [8:0]  cap_reg;
	logic        sgn_reg;
	logic [18:0] pending_results[$];
	int          errors = 0;
	bit          hold_off = 1'b0;
	bit          sink_free = 1'b1;

	sorted_key_table u_dut (.*);

	always #4 clk = ~clk;

	function automatic int key_order(logic [31:0] a, logic [31:0] b);
		logic [31:0] x, y;
		x = sgn_reg ? a ^ 32'h8000_0000 : a;
		y = sgn_reg ? b ^ 32'h8000_0000 : b;
		return (x < y) ? -1 : (x > y) ? 1 : 0;
	endfunction

	// Apply one action to the local table, return {count, index, found, status}.
	function automatic logic [18:0] table_apply(logic [2:0] act, logic [31:0] key);
		int unsigned lim, i, j, h, lo, hi, mid;
		logic st, fnd;
		logic [7:0] idx;
		logic [31:0] v;
		int c;
		st = 0; fnd = 0; idx = 0;
		lim = (cap_reg == 0) ? 1 : (cap_reg > NDEPTH) ? NDEPTH : cap_reg;
		case (act)
			ACT_CLEAR: fill_cnt = 0;
			ACT_APPEND: begin
				if (fill_cnt < lim) begin
					keys[fill_cnt] = key;
					fill_cnt++;
				end else st = 1;
			end
			ACT_INSERT: begin
				if (fill_cnt < lim) begin
					i = fill_cnt;
					fill_cnt++;
					while (i > 0 && key_order(keys[i-1], key) > 0) begin
						keys[i] = keys[i-1];
						i--;
					end
					keys[i] = key;
				end else st = 1;
			end
			ACT_LOOKUP: begin
				lo = 0; hi = fill_cnt;
				while (hi > lo) begin
					mid = (lo + hi) / 2;
					c = key_order(key, keys[mid]);
					if (c == 0) begin
						fnd = 1; idx = mid[7:0];
						break;
					end
					if (c > 0) lo = mid + 1;
					else hi = mid;
				end
			end
			ACT_SORT: begin
				h = 1;
				while (h <= fill_cnt) h = h * 3 + 1;
				while (h != 1) begin
					h = h / 3;
					for (i = h; i < fill_cnt; i++) begin
						v = keys[i];
						j = i;
						while (j >= h && key_order(v, keys[j-h]) < 0) begin
							keys[j] = keys[j-h];
							j -= h;
						end
						keys[j] = v;
					end
				end
			end
			default: ;
		endcase
		return {fill_cnt[8:0], idx, fnd, st};
	endfunction

	task automatic write_reg(logic [0:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CAPACITY) cap_reg = val;
		else sgn_reg = val[0];
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Offer one beat; queue the expectation when it is taken.
	task automatic send_beat(logic [2:0] act, logic [31:0] key, bit typed, logic [18:0] typed_res);
		logic [18:0] res;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, key, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = table_apply(act, key);
		if (typed && typed_res !== res) begin
			errors++;
			if (errors <= 10)
				$display("directed row disagrees with predictor: act %0d row %h pred %h",
					act, typed_res, res);
		end
		pending_results.push_back(res);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	// Receiver: stall pattern plus one long hold-off.
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= sink_free ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 40) == 0) sink_free <= ~sink_free;
	end

	always @(posedge clk) begin
		logic [18:0] exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", m_tdata[18:0]);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[18:0] !== exp_res) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: status %b/%b found %b/%b index %0d/%0d count %0d/%0d",
							exp_res[0], m_tdata[0], exp_res[1], m_tdata[1],
							exp_res[9:2], m_tdata[9:2], exp_res[18:10], m_tdata[18:10]);
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		row_t dir[$];
		int n, k;
		logic [2:0] act;
		fill_cnt = 0; cap_reg = 9'd256; sgn_reg = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: status and count only where obvious.
		dir.push_back('{ACT_LOOKUP, 32'h5, 1, 0, 0, 0, 0});
		dir.push_back('{ACT_SORT, 32'h0, 1, 0, 0, 0, 0});
		dir.push_back('{ACT_APPEND, 32'hFFFF_FFFF, 1, 0, 0, 0, 1});
		dir.push_back('{ACT_APPEND, 32'h0, 1, 0, 0, 0, 2});
		dir.push_back('{ACT_INSERT, 32'h8000_0000, 0, 0, 0, 0, 0});
		dir.push_back('{ACT_INSERT, 32'h8000_0000, 0, 0, 0, 0, 0});
		dir.push_back('{ACT_LOOKUP, 32'h0, 0, 0, 0, 0, 0});
		dir.push_back('{ACT_SORT, 32'h0, 0, 0, 0, 0, 0});
		dir.push_back('{ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
		dir.push_back('{ACT_LOOKUP, 32'h1234_5678, 0, 0, 0, 0, 0});
		dir.push_back('{3'd5, 32'h1, 1, 0, 0, 0, 4});
		dir.push_back('{3'd7, 32'hFFFF_FFFF, 1, 0, 0, 0, 4});
		dir.push_back('{ACT_CLEAR, 32'hDEAD_BEEF, 1, 0, 0, 0, 0});
		foreach (dir[i])
			send_beat(dir[i].act, dir[i].key, dir[i].chk,
				{dir[i].e_count, dir[i].e_index, dir[i].e_found, dir[i].e_status});
		go_idle();
		wait_drained();

		// Zero capacity acts as one; signed order with negative keys.
		write_reg(REG_CAPACITY, 9'd0);
		write_reg(REG_SIGNED, 1'b1);
		send_beat(ACT_INSERT, 32'hFFFF_FFFE, 1, {9'd1, 8'd0, 1'b0, 1'b0});
		send_beat(ACT_APPEND, 32'h7, 1, {9'd1, 8'd0, 1'b0, 1'b1});
		send_beat(ACT_INSERT, 32'h7, 1, {9'd1, 8'd0, 1'b0, 1'b1});
		send_beat(ACT_LOOKUP, 32'hFFFF_FFFE, 1, {9'd1, 8'd0, 1'b1, 1'b0});
		go_idle();
		wait_drained();

		// Random phases with assorted settings, fill limited to keep sorts short.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: write_reg(REG_CAPACITY, 9'd256);
				1: write_reg(REG_CAPACITY, 9'd511);
				2: write_reg(REG_CAPACITY, 9'd3);
				default: write_reg(REG_CAPACITY, 9'($urandom_range(1, 40)));
			endcase
			write_reg(REG_SIGNED, 1'($urandom_range(0, 1)));
			if (ph == 2) write_reg(REG_CAPACITY, 9'd2);  // lowered below a held fill
			n = 110;
			k = 0;
			while (k < n) begin
				if (ph == 3 && k == 20) begin
					hold_off = 1'b1;
					fork
						begin
							repeat (300) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				if (ph == 1 && k == 60) begin
					go_idle();
					wait_drained();
				end
				// Mostly inserts and lookups into a sorted table.
				case ($urandom_range(0, 19))
					0: act = (fill_cnt > 20 || $urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_APPEND;
					1, 2: act = ACT_APPEND;
					3, 4, 5, 6, 7: act = ACT_INSERT;
					8: act = (fill_cnt <= 40) ? ACT_SORT : ACT_CLEAR;
					9: act = 3'($urandom_range(5, 7));
					default: act = ACT_LOOKUP;
				endcase
				if (fill_cnt >= 60 && (act == ACT_APPEND || act == ACT_INSERT)) act = ACT_CLEAR;
				if (act == ACT_LOOKUP && fill_cnt > 0 && $urandom_range(0, 1))
					send_beat(act, keys[$urandom_range(0, fill_cnt - 1)], 0, '0);
				else
					send_beat(act, rand_key(), 0, '0);
				k++;
				if ($urandom_range(0, 7) == 0) begin
					go_idle();
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
			go_idle();
			wait_drained();
		end

		// One full-depth run: fill to 256 then overflow.
		write_reg(REG_CAPACITY, 9'd256);
		send_beat(ACT_CLEAR, 32'h0, 0, '0);
		for (int i = 0; i < 257; i++)
			send_beat(ACT_APPEND, $urandom(), 0, '0);
		send_beat(ACT_INSERT, 32'h0, 0, '0);
		send_beat(ACT_LOOKUP, keys[255], 0, '0);
		send_beat(ACT_CLEAR, 32'h0, 0, '0);
		go_idle();
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
